// ----- hw/rtl/multi_level_priority_fifo_unit_macros.svh -----
// Assertion macros shared by the checker of the priority queue block.
// Needs nothing else; include it by its bare file name.
`ifndef MULTI_LEVEL_PRIORITY_FIFO_UNIT_MACROS_SVH
`define MULTI_LEVEL_PRIORITY_FIFO_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MLPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("priority queue assertion failed");

// Next-cycle implication, checked out of reset.
`define MLPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("priority queue assertion failed");

`endif

// ----- hw/rtl/mlpf_pkg.sv -----
// Types and constants for the strict-priority multi-queue.
// No dependencies; used by every module of the block except mlpf_ram.
package mlpf_pkg;

    localparam int OP_W     = 1;
    localparam int PRIO_W   = 4;
    localparam int DIN_W    = 32;
    localparam int STATUS_W = 2;
    localparam int DOUT_W   = 32;

    localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
    localparam logic [OP_W-1:0] OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } t_dp_cmd;

endpackage

// ----- hw/rtl/mlpf_ram.sv -----
// Generic single-port RAM with a registered read.
// No dependencies.
module mlpf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/mlpf_datapath.sv -----
// Datapath of the priority queue: per-level pointers and counts, the item store
// and the result register. Depends on mlpf_pkg and mlpf_ram.
module mlpf_datapath #(
    parameter int LEVELS     = 10,
    parameter int DEPTH      = 512,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mlpf_pkg::t_dp_cmd                 i_cmd,
    input  logic [mlpf_pkg::OP_W-1:0]         i_op,
    input  logic [mlpf_pkg::PRIO_W-1:0]       i_prio,
    input  logic [mlpf_pkg::DIN_W-1:0]        i_data,
    output logic [mlpf_pkg::STATUS_W-1:0]     o_status,
    output logic [mlpf_pkg::DOUT_W-1:0]       o_data,
    output logic [mlpf_pkg::PRIO_W-1:0]       o_served,
    output logic                              o_all_empty
);
    import mlpf_pkg::*;

    localparam int SW = (DATA_WIDTH < DIN_W) ? DATA_WIDTH : DIN_W;
    localparam int LW = $clog2(LEVELS);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(LEVELS * DEPTH);

    logic [OP_W-1:0]     r_op;
    logic [PRIO_W-1:0]   r_prio;
    logic [SW-1:0]       r_data;

    logic [PW-1:0]       r_head  [LEVELS];
    logic [PW-1:0]       r_tail  [LEVELS];
    logic [CW-1:0]       r_count [LEVELS];

    logic [STATUS_W-1:0] r_status;
    logic [LW-1:0]       r_served;
    logic                r_pop_ok;

    logic [STATUS_W-1:0] r_out_status;
    logic [DOUT_W-1:0]   r_out_data;
    logic [PRIO_W-1:0]   r_out_served;
    logic                r_out_empty;

    logic [LEVELS-1:0]   nonempty;
    logic [LW-1:0]       pop_lvl;
    logic                in_range;
    logic [LW-1:0]       sel;
    logic [PW-1:0]       hd;
    logic [PW-1:0]       tl;
    logic [CW-1:0]       cnt;
    logic                do_push;
    logic                do_pop;
    logic [STATUS_W-1:0] n_status;
    logic [AW-1:0]       addr;
    logic [PW-1:0]       ptr;
    logic [SW-1:0]       rdata;

    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            nonempty[i] = (r_count[i] != '0);
        end
    end

    always_comb begin
        pop_lvl = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (nonempty[i]) begin
                pop_lvl = LW'(i);
            end
        end
    end

    always_comb begin
        in_range = ({1'b0, r_prio} < (PRIO_W + 1)'(LEVELS));
        if (r_op == OP_REMOVE) begin
            sel = pop_lvl;
        end else if (in_range) begin
            sel = r_prio[LW-1:0];
        end else begin
            sel = '0;
        end
        hd  = r_head[sel];
        tl  = r_tail[sel];
        cnt = r_count[sel];
        do_push = 1'b0;
        do_pop  = 1'b0;
        if (r_op == OP_REMOVE) begin
            if (|nonempty) begin
                n_status = ST_OK;
                do_pop   = 1'b1;
            end else begin
                n_status = ST_EMPTY;
            end
        end else if (!in_range) begin
            n_status = ST_RANGE;
        end else if (cnt == CW'(DEPTH)) begin
            n_status = ST_FULL;
        end else begin
            n_status = ST_OK;
            do_push  = 1'b1;
        end
        ptr  = do_push ? tl : hd;
        addr = AW'(sel) * AW'(DEPTH) + AW'(ptr);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= i_op;
            r_prio <= i_prio;
            r_data <= i_data[SW-1:0];
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_served <= (do_push || do_pop) ? sel : '0;
            r_pop_ok <= do_pop;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_data   <= r_pop_ok ? DOUT_W'(rdata) : '0;
            r_out_served <= PRIO_W'(r_served);
            r_out_empty  <= ~|nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            if (do_push) begin
                r_tail[sel]  <= (tl == PW'(DEPTH - 1)) ? '0 : tl + PW'(1);
                r_count[sel] <= cnt + CW'(1);
            end
            if (do_pop) begin
                r_head[sel]  <= (hd == PW'(DEPTH - 1)) ? '0 : hd + PW'(1);
                r_count[sel] <= cnt - CW'(1);
            end
        end
    end

    mlpf_ram #(
        .WIDTH (SW),
        .DEPTH (LEVELS * DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec & do_push),
        .i_re    (i_cmd.exec & do_pop),
        .i_addr  (addr),
        .i_wdata (r_data),
        .o_rdata (rdata)
    );

    assign o_status    = r_out_status;
    assign o_data      = r_out_data;
    assign o_served    = r_out_served;
    assign o_all_empty = r_out_empty;

endmodule

// ----- hw/rtl/mlpf_ctrl.sv -----
// Controller of the priority queue: sequences accept, execute and result load,
// and owns the result valid flag. Depends on mlpf_pkg.
module mlpf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mlpf_pkg::t_dp_cmd o_cmd
);
    import mlpf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;

    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_out_vld = r_out_vld & ~i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

// ----- hw/rtl/multi_level_priority_fifo_unit.sv -----
// Top level of the strict-priority multi-queue.
// Depends on mlpf_pkg, mlpf_ctrl, mlpf_datapath and mlpf_ram.
//
// The block keeps LEVELS circular queues of DEPTH words each in one RAM. An insert
// item names a level and a word; a remove item pops the head of the lowest-numbered
// non-empty level. Every item gives exactly one result. One item is worked on at a
// time: it is taken in the idle state, executed in the exec state (one RAM access plus
// the pointer and count update of the chosen level), and its result is loaded into the
// output register in the done state, which waits while an older result is held there;
// only then is a new item taken. A result waiting in the output register does not stop
// the next item from being taken. The item store needs no clearing after reset.
module multi_level_priority_fifo_unit #(
    parameter int LEVELS     = 10,
    parameter int DEPTH      = 512,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // data_in
    input  logic [4:0]  i_s_axis_tuser,  // op, priority_req
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // data_out
    output logic [6:0]  o_m_axis_tuser   // status, served_level, all_empty
);
    import mlpf_pkg::*;

    t_dp_cmd             cmd;
    logic [STATUS_W-1:0] status;
    logic [PRIO_W-1:0]   served;
    logic                all_empty;

    mlpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    mlpf_datapath #(
        .LEVELS     (LEVELS),
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_op        (i_s_axis_tuser[OP_W-1:0]),
        .i_prio      (i_s_axis_tuser[OP_W+PRIO_W-1:OP_W]),
        .i_data      (i_s_axis_tdata),
        .o_status    (status),
        .o_data      (o_m_axis_tdata),
        .o_served    (served),
        .o_all_empty (all_empty)
    );

    assign o_m_axis_tuser = {all_empty, served, status};

endmodule

// ----- hw/rtl/mlpf_checker.sv -----
// Port-level checker for the priority queue, bound to the top level.
// Depends on mlpf_pkg and multi_level_priority_fifo_unit_macros.svh.
`include "multi_level_priority_fifo_unit_macros.svh"

module mlpf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [6:0]  o_m_axis_tuser
);
    import mlpf_pkg::*;

    logic [STATUS_W-1:0] out_status;
    logic [PRIO_W-1:0]   out_served;
    logic                out_empty;
    logic [38:0]         out_word;
    logic                out_stall;
    logic                out_failed;
    logic                out_zero;
    logic                out_no_item;
    logic                in_take;

    assign out_status  = o_m_axis_tuser[1:0];
    assign out_served  = o_m_axis_tuser[5:2];
    assign out_empty   = o_m_axis_tuser[6];
    assign out_word    = {o_m_axis_tuser, o_m_axis_tdata};
    assign out_stall   = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_failed  = o_m_axis_tvalid && (out_status != ST_OK);
    assign out_zero    = (o_m_axis_tdata == '0) && (out_served == '0);
    assign out_no_item = o_m_axis_tvalid && (out_status == ST_EMPTY);
    assign in_take     = i_s_axis_tvalid && o_s_axis_tready;

    `MLPF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_axis_tvalid && $stable(out_word))
    `MLPF_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, out_failed, out_zero)
    `MLPF_ASSERT_NOW(a_empty_flag, i_clk, i_rst_n, out_no_item, out_empty)
    `MLPF_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, in_take, !o_s_axis_tready)

endmodule

bind multi_level_priority_fifo_unit mlpf_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ----- dv/multi_level_priority_fifo_unit_tb.sv -----
// Self-checking testbench for the strict-priority multi-queue: a directed table, then random
// insert and remove items under several idling patterns, checked against a queue predictor.
// Needs mlpf_pkg and multi_level_priority_fifo_unit.
module multi_level_priority_fifo_unit_tb;
    import mlpf_pkg::*;

    localparam int NUM_LEVELS = 10;
    localparam int LEVEL_DEPTH = 512;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DOUT_W-1:0]   dout;
        logic [PRIO_W-1:0]   served;
        logic                all_empty;
    } t_queue_result;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [PRIO_W-1:0]   prio;
        logic [DIN_W-1:0]    data;
        logic                typed;
        t_queue_result       res;
    } t_table_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;  // data_in
    logic [4:0]  i_s_axis_tuser = '0;  // op, priority_req
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;       // data_out
    logic [6:0]  o_m_axis_tuser;       // status, served_level, all_empty

    logic [DIN_W-1:0] level_words [NUM_LEVELS][$];
    t_queue_result    expected_results [$];
    int               mismatch_cnt = 0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    logic             hold_go = 1'b0;
    logic             hold_active = 1'b0;

    // Rows with a typed result are checked against it; the others against the predictor.
    t_table_row dir_table [21] = '{
        '{OP_REMOVE, 4'd0,  32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0, 4'd0, 1'b1}},
        '{OP_INSERT, 4'd15, 32'h1111_1111, 1'b1, '{ST_RANGE, 32'h0, 4'd0, 1'b1}},
        '{OP_INSERT, 4'd10, 32'h2222_2222, 1'b1, '{ST_RANGE, 32'h0, 4'd0, 1'b1}},
        '{OP_INSERT, 4'd0,  32'h0000_0000, 1'b1, '{ST_OK,    32'h0, 4'd0, 1'b0}},
        '{OP_INSERT, 4'd9,  32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'h0, 4'd9, 1'b0}},
        '{OP_INSERT, 4'd5,  32'hA5A5_A5A5, 1'b1, '{ST_OK,    32'h0, 4'd5, 1'b0}},
        '{OP_INSERT, 4'd9,  32'h5A5A_5A5A, 1'b1, '{ST_OK,    32'h0, 4'd9, 1'b0}},
        '{OP_REMOVE, 4'd15, 32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'h0, 4'd0, 1'b0}},
        '{OP_REMOVE, 4'd0,  32'h0000_0000, 1'b1, '{ST_OK,    32'hA5A5_A5A5, 4'd5, 1'b0}},
        '{OP_REMOVE, 4'd9,  32'h1234_5678, 1'b1, '{ST_OK,    32'hFFFF_FFFF, 4'd9, 1'b0}},
        '{OP_INSERT, 4'd12, 32'hDEAD_BEEF, 1'b1, '{ST_RANGE, 32'h0, 4'd0, 1'b0}},
        '{OP_REMOVE, 4'd0,  32'h0000_0000, 1'b1, '{ST_OK,    32'h5A5A_5A5A, 4'd9, 1'b1}},
        '{OP_REMOVE, 4'd0,  32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0, 4'd0, 1'b1}},
        '{OP_INSERT, 4'd3,  32'h1234_5678, 1'b0, '0},
        '{OP_INSERT, 4'd1,  32'h8765_4321, 1'b0, '0},
        '{OP_INSERT, 4'd3,  32'h0000_FFFF, 1'b0, '0},
        '{OP_REMOVE, 4'd0,  32'hFFFF_0000, 1'b0, '0},
        '{OP_REMOVE, 4'd7,  32'h0000_0000, 1'b0, '0},
        '{OP_INSERT, 4'd10, 32'hFFFF_FFFF, 1'b1, '{ST_RANGE, 32'h0, 4'd0, 1'b0}},
        '{OP_REMOVE, 4'd0,  32'h0000_0000, 1'b0, '0},
        '{OP_REMOVE, 4'd0,  32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0, 4'd0, 1'b1}}
    };

    multi_level_priority_fifo_unit #(
        .LEVELS     (NUM_LEVELS),
        .DEPTH      (LEVEL_DEPTH),
        .DATA_WIDTH (32)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_queue_result predict_queue_op(input logic [OP_W-1:0] op,
                                                       input logic [PRIO_W-1:0] prio,
                                                       input logic [DIN_W-1:0] data);
        t_queue_result r;
        bit            none_left;
        r = '{ST_OK, '0, '0, 1'b0};
        if (op == OP_INSERT) begin
            if (prio >= NUM_LEVELS) begin
                r.status = ST_RANGE;
            end else if (level_words[prio].size() >= LEVEL_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                level_words[prio].push_back(data);
                r.served = prio;
            end
        end else begin
            r.status = ST_EMPTY;
            for (int lvl = 0; lvl < NUM_LEVELS; lvl++) begin
                if (r.status == ST_EMPTY && level_words[lvl].size() != 0) begin
                    r.status = ST_OK;
                    r.dout = level_words[lvl].pop_front();
                    r.served = lvl[PRIO_W-1:0];
                end
            end
        end
        none_left = 1'b1;
        for (int lvl = 0; lvl < NUM_LEVELS; lvl++) begin
            if (level_words[lvl].size() != 0) begin
                none_left = 1'b0;
            end
        end
        r.all_empty = none_left;
        return r;
    endfunction

    function automatic int words_held();
        int total;
        total = 0;
        for (int lvl = 0; lvl < NUM_LEVELS; lvl++) begin
            total += level_words[lvl].size();
        end
        return total;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("Mismatch on %s: got %h, expected %h", field, got, want);
        mismatch_cnt++;
    endtask

    // Offers one item and returns at the edge where it is taken; tvalid stays high after.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [PRIO_W-1:0] prio,
                             input logic [DIN_W-1:0] data, input bit typed,
                             input t_queue_result typed_res);
        t_queue_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= data;
        i_s_axis_tuser <= {prio, op};
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        predicted = predict_queue_op(op, prio, data);
        expected_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic send_random_item();
        logic [PRIO_W-1:0] prio;
        logic [DIN_W-1:0]  data;
        if ($urandom_range(99) < 10) begin
            prio = 4'($urandom_range(15, NUM_LEVELS));
        end else begin
            prio = 4'($urandom_range(NUM_LEVELS - 1));
        end
        case ($urandom_range(19))
            0: data = '0;
            1: data = '1;
            default: data = $urandom;
        endcase
        send_item($urandom_range(1) ? OP_REMOVE : OP_INSERT, prio, data, 1'b0, '0);
    endtask

    task automatic run_random_phase(input int n_items, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n_items; k++) begin
            send_random_item();
        end
    endtask

    always @(posedge i_clk) begin
        i_m_axis_tready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
    end

    // Long hold-off of the result side so that the block backs up into its input.
    initial begin : long_hold
        int n;
        wait (hold_go);
        hold_active <= 1'b1;
        for (n = 0; n < 1500; n++) begin
            @(posedge i_clk);
        end
        hold_active <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_m_axis_tdata, '0);
            end else begin
                want = expected_results.pop_front();
                if (o_m_axis_tuser[1:0] != want.status) begin
                    report_mismatch("status", 32'(o_m_axis_tuser[1:0]), 32'(want.status));
                end
                if (o_m_axis_tdata != want.dout) begin
                    report_mismatch("data_out", o_m_axis_tdata, want.dout);
                end
                if (o_m_axis_tuser[5:2] != want.served) begin
                    report_mismatch("served_level", 32'(o_m_axis_tuser[5:2]),
                                    32'(want.served));
                end
                if (o_m_axis_tuser[6] != want.all_empty) begin
                    report_mismatch("all_empty", 32'(o_m_axis_tuser[6]), 32'(want.all_empty));
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int fill_lvl;
        int n_fill;
        int n_drain;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int row = 0; row < 21; row++) begin
            send_item(dir_table[row].op, dir_table[row].prio, dir_table[row].data,
                      dir_table[row].typed, dir_table[row].res);
        end

        run_random_phase(100, 0, 0);

        // Fill one level past its depth while results are held back, then empty everything.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fill_lvl = $urandom_range(NUM_LEVELS - 1);
        n_fill = LEVEL_DEPTH - level_words[fill_lvl].size() + 8;
        hold_go = 1'b1;
        for (int k = 0; k < n_fill; k++) begin
            send_item(OP_INSERT, 4'(fill_lvl), $urandom, 1'b0, '0);
        end
        n_drain = words_held() + 4;
        for (int k = 0; k < n_drain; k++) begin
            send_item(OP_REMOVE, 4'($urandom_range(15)), $urandom, 1'b0, '0);
        end

        run_random_phase(150, 88, 0);
        run_random_phase(150, 0, 88);
        run_random_phase(150, 17, 17);
        run_random_phase(50, 0, 0);
        i_s_axis_tvalid <= 1'b0;

        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/mlpf_pkg.sv
hw/rtl/mlpf_ram.sv
hw/rtl/mlpf_datapath.sv
hw/rtl/mlpf_ctrl.sv
hw/rtl/multi_level_priority_fifo_unit.sv
hw/rtl/mlpf_checker.sv
dv/multi_level_priority_fifo_unit_tb.sv
